// File: rtl/sorted_key_table_assert.svh
// Assertion macros used by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SKT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SKT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table assertion failed");

`endif

// File: rtl/skt_pkg.sv
// Package with sizes, command and status codes, and the result word type.
package skt_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 64;
  localparam int KEY_W      = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = CNT_W + 8;
  localparam int POS_W      = 9;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_WKEY   = 3'd3;
  localparam logic [2:0] CMD_WVAL   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic signed [31:0] key_out;
    logic [63:0]       value_out;
    logic [POS_W-1:0]  entry_count;
  } res_t;

endpackage

// File: rtl/skt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/skt_ctrl.sv
// Command sequencer: binary search, entry shift, indexed access and result build.
module skt_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        command,
  input  logic signed [31:0]                key,
  input  logic [63:0]                       value,
  input  logic [7:0]                        index,
  output logic                              res_valid,
  input  logic                              res_take,
  output skt_pkg::res_t                     res,
  output logic [skt_pkg::ADDR_W-1:0]        raddr,
  output logic                              key_we,
  output logic                              val_we,
  output logic [skt_pkg::ADDR_W-1:0]        waddr,
  output logic signed [31:0]                wkey,
  output logic [skt_pkg::VALUE_BITS-1:0]    wval,
  input  logic signed [31:0]                rkey,
  input  logic [skt_pkg::VALUE_BITS-1:0]    rval
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCH   = 3'd1;
  localparam logic [2:0] S_SCMP   = 3'd2;
  localparam logic [2:0] S_POST   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_INS    = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]            state;
  logic [2:0]            cmd;
  logic signed [31:0]    key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [7:0]            idx_r;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hip1;
  logic [ADDR_W-1:0]     mid;
  logic [CNT_W-1:0]      pos;
  logic                  hit;
  logic [CNT_W-1:0]      ptr;
  logic                  pend;
  logic [ADDR_W-1:0]     wa;
  logic                  wr_pend;
  logic [1:0]            status_r;
  logic                  found_r;
  logic [POS_W-1:0]      position_r;
  logic signed [31:0]    key_out_r;
  logic [VALUE_BITS-1:0] val_out_r;

  logic [CNT_W:0]        mid_sum;
  logic [ADDR_W-1:0]     mid_c;
  logic                  in_range;
  logic                  more;

  assign mid_sum  = {1'b0, lo} + {1'b0, hip1} - (CNT_W + 1)'(1);
  assign mid_c    = ADDR_W'(mid_sum >> 1);
  assign in_range = CMP_W'(index) < CMP_W'(count);
  assign more     = ptr > pos;
  assign in_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status      = status_r;
    res.found       = found_r;
    res.position    = position_r;
    res.key_out     = key_out_r;
    res.value_out   = 64'(val_out_r);
    res.entry_count = POS_W'(count);
  end

  always_comb begin
    raddr  = ADDR_W'(index);
    key_we = 1'b0;
    val_we = 1'b0;
    waddr  = ADDR_W'(idx_r);
    wkey   = key_r;
    wval   = val_r;
    case (state)
      S_SRCH: begin
        raddr = mid_c;
      end
      S_SHIFT: begin
        raddr  = ADDR_W'(ptr - CNT_W'(1));
        waddr  = wa;
        wkey   = rkey;
        wval   = rval;
        key_we = pend;
        val_we = pend;
      end
      S_INS: begin
        waddr  = ADDR_W'(pos);
        key_we = 1'b1;
        val_we = 1'b1;
      end
      S_DONE: begin
        key_we = wr_pend && (cmd == CMD_WKEY);
        val_we = wr_pend && (cmd == CMD_WVAL);
      end
      default: begin
        raddr = ADDR_W'(index);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            key_r      <= key;
            val_r      <= value[VALUE_BITS-1:0];
            idx_r      <= index;
            hit        <= 1'b0;
            found_r    <= 1'b0;
            position_r <= '0;
            key_out_r  <= '0;
            val_out_r  <= '0;
            status_r   <= ST_OK;
            lo         <= '0;
            hip1       <= count;
            wr_pend    <= 1'b0;
            case (command)
              CMD_INSERT: begin
                if (count >= CNT_W'(CAPACITY)) begin
                  status_r <= ST_FULL;
                  state    <= S_DONE;
                end else begin
                  state <= S_SRCH;
                end
              end
              CMD_FIND: begin
                state <= S_SRCH;
              end
              CMD_READ: begin
                if (in_range) begin
                  state <= S_RDWAIT;
                end else begin
                  status_r  <= ST_BOUNDS;
                  key_out_r <= '1;
                  state     <= S_DONE;
                end
              end
              CMD_WKEY, CMD_WVAL: begin
                if (in_range) begin
                  wr_pend <= 1'b1;
                end else begin
                  status_r <= ST_BOUNDS;
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo < hip1) begin
            mid   <= mid_c;
            state <= S_SCMP;
          end else begin
            pos   <= lo;
            state <= S_POST;
          end
        end
        S_SCMP: begin
          if (rkey == key_r) begin
            hit   <= 1'b1;
            pos   <= CNT_W'(mid);
            state <= S_POST;
          end else if (rkey < key_r) begin
            lo    <= CNT_W'(mid) + CNT_W'(1);
            state <= S_SRCH;
          end else begin
            hip1  <= CNT_W'(mid);
            state <= S_SRCH;
          end
        end
        S_POST: begin
          if (cmd == CMD_FIND) begin
            found_r    <= hit;
            position_r <= POS_W'(pos);
            state      <= S_DONE;
          end else begin
            ptr   <= count;
            pend  <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend <= more;
          wa   <= ADDR_W'(ptr);
          if (more) begin
            ptr <= ptr - CNT_W'(1);
          end else if (!pend) begin
            state <= S_INS;
          end
        end
        S_INS: begin
          count      <= count + CNT_W'(1);
          position_r <= POS_W'(pos);
          state      <= S_DONE;
        end
        S_RDWAIT: begin
          key_out_r <= rkey;
          val_out_r <= rval;
          state     <= S_DONE;
        end
        S_DONE: begin
          wr_pend <= 1'b0;
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/sorted_key_table.sv
// Top level of the sorted key table: storage, sequencer and output register.
// The table holds up to 256 signed keys, kept in ascending order by insert, each with a
// 64-bit value, and starts empty after reset. It takes one command word at a time and
// stalls its input until that command's result has been handed to the output register.
// A find runs a binary search of at most 9 steps, and an insert runs the same search and
// then moves every entry above the new position up by one place; the single read port
// of the key and value memories paces both the search and the shift. A result waits in
// the output register while the next command is already being worked on.
module sorted_key_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] key,
  input  logic [63:0]        value,
  input  logic [7:0]         index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic [8:0]         position,
  output logic signed [31:0] key_out,
  output logic [63:0]        value_out,
  output logic [8:0]         entry_count
);
  import skt_pkg::*;

  `include "sorted_key_table_assert.svh"

  logic                  res_valid;
  logic                  res_take;
  res_t                  res;
  res_t                  out_r;
  logic [ADDR_W-1:0]     raddr;
  logic                  key_we;
  logic                  val_we;
  logic [ADDR_W-1:0]     waddr;
  logic signed [31:0]    wkey;
  logic [VALUE_BITS-1:0] wval;
  logic signed [31:0]    rkey;
  logic [VALUE_BITS-1:0] rval;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .key       (key),
    .value     (value),
    .index     (index),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .raddr     (raddr),
    .key_we    (key_we),
    .val_we    (val_we),
    .waddr     (waddr),
    .wkey      (wkey),
    .wval      (wval),
    .rkey      (rkey),
    .rval      (rval)
  );

  skt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  skt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rval)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign status      = out_r.status;
  assign found       = out_r.found;
  assign position    = out_r.position;
  assign key_out     = out_r.key_out;
  assign value_out   = out_r.value_out;
  assign entry_count = out_r.entry_count;

  `SKT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SKT_ASSERT_IMP(a_count_bound, out_valid, entry_count <= 9'(CAPACITY))
  `SKT_ASSERT_IMP(a_full_only_when_full, out_valid && (status == ST_FULL),
                  entry_count == 9'(CAPACITY))
  `SKT_ASSERT_IMP(a_no_found_on_error, out_valid && (status != ST_OK), !found)

endmodule

// File: verif/tb.sv
// Testbench for the sorted key table: directed and random command words checked against a model.
module tb;
  import skt_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [31:0] MISSING_KEY = -32'sd1;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = CMD_INSERT;
  logic signed [31:0] key = '0;
  logic [63:0]        value = '0;
  logic [7:0]         index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic               found;
  logic [8:0]         position;
  logic signed [31:0] key_out;
  logic [63:0]        value_out;
  logic [8:0]         entry_count;

  logic signed [31:0] tbl_key [CAPACITY];
  logic [63:0]        tbl_val [CAPACITY];
  int                 tbl_count = 0;
  res_t               pending [$];
  int                 errors = 0;
  bit                 no_idle = 1'b0;
  int                 hold_requests = 0;
  int                 hold_served = 0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;

  sorted_key_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .key(key),
    .value(value),
    .index(index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found(found),
    .position(position),
    .key_out(key_out),
    .value_out(value_out),
    .entry_count(entry_count)
  );

  always #1 clk = ~clk;

  function automatic int locate_key(input logic signed [31:0] k, output bit hit);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_count - 1;
    hit = 1'b0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tbl_key[mid] == k) begin
        hit = 1'b1;
        return mid;
      end
      if (tbl_key[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic res_t apply_command(input logic [2:0] c, input logic signed [31:0] k,
                                         input logic [63:0] v, input logic [7:0] idx);
    res_t r;
    bit hit;
    int pos;
    r = '0;
    case (c)
      CMD_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = locate_key(k, hit);
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = k;
          tbl_val[pos] = v & VALUE_MASK;
          tbl_count++;
          r.position = POS_W'(pos);
        end
      end
      CMD_FIND: begin
        pos = locate_key(k, hit);
        r.found = hit;
        r.position = POS_W'(pos);
      end
      CMD_READ: begin
        if (idx < tbl_count) begin
          r.key_out = tbl_key[idx];
          r.value_out = tbl_val[idx];
        end else begin
          r.status = ST_BOUNDS;
          r.key_out = MISSING_KEY;
        end
      end
      CMD_WKEY: begin
        if (idx < tbl_count) tbl_key[idx] = k;
        else r.status = ST_BOUNDS;
      end
      CMD_WVAL: begin
        if (idx < tbl_count) tbl_val[idx] = v & VALUE_MASK;
        else r.status = ST_BOUNDS;
      end
      default: ;
    endcase
    r.entry_count = POS_W'(tbl_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (r < 40 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)] + 32'sd1;
    if (r < 70) return int'($urandom_range(0, 16)) - 8;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_index();
    if (tbl_count > 0 && $urandom_range(0, 99) < 70) return 8'($urandom_range(0, tbl_count - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [2:0] c, input logic signed [31:0] k,
                           input logic [63:0] v, input logic [7:0] idx);
    int gap;
    command <= c;
    key <= k;
    value <= v;
    index <= idx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(apply_command(c, k, v, idx));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_word();
    int r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) c = CMD_INSERT;
    else if (r < 60) c = CMD_FIND;
    else if (r < 78) c = CMD_READ;
    else if (r < 87) c = CMD_WKEY;
    else if (r < 96) c = CMD_WVAL;
    else c = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    send_word(c, pick_key(), {$urandom, $urandom}, pick_index());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic test_empty_table();
    send_word(CMD_READ, KEY_MAX, '0, 8'd0);
    send_word(CMD_READ, KEY_MIN, '1, 8'd255);
    send_word(CMD_WKEY, KEY_MIN, '0, 8'd0);
    send_word(CMD_WVAL, '0, '1, 8'd255);
    send_word(CMD_FIND, 32'sd5, '0, 8'd0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      send_word(3'(c), MISSING_KEY, '1, 8'hff);
    end
    drain();
  endtask

  task automatic test_directed_entries();
    send_word(CMD_INSERT, KEY_MAX, '1, 8'd0);
    send_word(CMD_INSERT, KEY_MIN, '0, 8'd0);
    send_word(CMD_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef, 8'd0);
    send_word(CMD_INSERT, MISSING_KEY, 64'hfedc_ba98_7654_3210, 8'd0);
    // An equal key goes in front of the one already held.
    send_word(CMD_INSERT, 32'sd0, 64'h5555_aaaa_5555_aaaa, 8'd0);
    send_word(CMD_FIND, KEY_MIN, '0, 8'd0);
    send_word(CMD_FIND, KEY_MAX, '0, 8'd0);
    send_word(CMD_FIND, 32'sd0, '0, 8'd0);
    send_word(CMD_FIND, 32'sd7, '0, 8'd0);
    send_word(CMD_READ, '0, '0, 8'd0);
    send_word(CMD_READ, '0, '0, 8'd4);
    send_word(CMD_READ, '0, '0, 8'd5);
    // Overwriting the smallest key with the largest leaves the table out of order.
    send_word(CMD_WKEY, KEY_MAX, '0, 8'd0);
    send_word(CMD_FIND, KEY_MAX, '0, 8'd0);
    send_word(CMD_WVAL, '0, 64'haaaa_5555_aaaa_5555, 8'd4);
    send_word(CMD_READ, '0, '0, 8'd4);
    send_word(CMD_WKEY, 32'sd1, '0, 8'd5);
    send_word(CMD_WVAL, '0, '1, 8'd200);
    drain();
  endtask

  task automatic test_random_traffic(input int words);
    for (int n = 0; n < words; n++) begin
      no_idle = (n < words / 8);
      random_word();
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_back_pressure();
    hold_requests <= hold_requests + 1;
    no_idle = 1'b1;
    for (int n = 0; n < 24; n++) random_word();
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_fill_to_capacity();
    while (tbl_count < CAPACITY) send_word(CMD_INSERT, pick_key(), {$urandom, $urandom}, '0);
    send_word(CMD_INSERT, KEY_MIN, '1, 8'd0);
    send_word(CMD_INSERT, KEY_MAX, '1, 8'd0);
    send_word(CMD_FIND, KEY_MIN, '0, 8'd0);
    send_word(CMD_READ, '0, '0, 8'd255);
    send_word(CMD_READ, '0, '0, 8'd0);
    drain();
  endtask

  always @(posedge clk) begin : receiver
    int r;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      stall_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic report(input string name, input logic [63:0] want, input logic [63:0] got);
    $error("%s mismatch: expected %0h, got %0h", name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        want = pending.pop_front();
        if (status !== want.status) report("status", 64'(want.status), 64'(status));
        if (found !== want.found) report("found", 64'(want.found), 64'(found));
        if (position !== want.position)
          report("position", 64'(want.position), 64'(position));
        if (key_out !== want.key_out)
          report("key_out", {32'd0, want.key_out}, {32'd0, key_out});
        if (value_out !== want.value_out) report("value_out", want.value_out, value_out);
        if (entry_count !== want.entry_count)
          report("entry_count", 64'(want.entry_count), 64'(entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_entries();
    test_random_traffic(550);
    test_back_pressure();
    test_fill_to_capacity();
    test_random_traffic(650);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sorted_key_table.f
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
verif/tb.sv
